// ----- sv/sparse_column_pattern_builder_macros.svh -----
// ----------------------------------------------------------------------------
// Sparse column pattern builder assertion macros
// Short forms for the concurrent checks of the pattern builder.
// ----------------------------------------------------------------------------
`ifndef SPARSE_COLUMN_PATTERN_BUILDER_MACROS_SVH
`define SPARSE_COLUMN_PATTERN_BUILDER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCPB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SCPB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/scpb_pkg.sv -----
// ----------------------------------------------------------------------------
// Sparse column pattern builder package
// Sizes, field widths and codes shared by the pattern builder files.
// ----------------------------------------------------------------------------
package scpb_pkg;

  localparam int MAX_EQUATIONS    = 64;
  localparam int SLOTS_PER_COLUMN = 16;

  localparam int COL_W    = $clog2(MAX_EQUATIONS);
  localparam int ROW_W    = $clog2(MAX_EQUATIONS);
  localparam int EQN_W    = $clog2(MAX_EQUATIONS + 1);
  localparam int CNT_W    = $clog2(SLOTS_PER_COLUMN + 1);
  localparam int ST_DEPTH = MAX_EQUATIONS * SLOTS_PER_COLUMN;
  localparam int ST_AW    = $clog2(ST_DEPTH);

  // Interface field widths are fixed.
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 3;
  localparam int POS_W      = 10;
  localparam int TOT_W      = 11;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_USER_W = 5;

  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_INACTIVE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_ENTRY    = 3'd5;

endpackage

// ----- sv/scpb_ram.sv -----
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module scpb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

// ----- sv/sparse_column_pattern_builder.sv -----
// ----------------------------------------------------------------------------
// Sparse column pattern builder
// Keeps an ascending row list per column in a slot memory, inserts rows by
// shifting larger entries up, and streams a column with compacted positions.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready  | tuser op, tdata column/row_eqno, tlast
//  out_    | out | out_tvalid/out_tready| tuser status/flags, tdata, tlast
//  cfg_    | in  | cfg_wr_en            | cfg_wr_data num_equations
//
// Clear and rejected items pass through the check and emit states. The time
// of an insert into a column of length L is set by the slot scan and the
// shift, each one memory access a cycle. A read of column c is set by the
// serial sum over the column length memory, then streams one entry a cycle
// while the output register is not stalled; an empty column gives one result.
// Column lengths sit behind per-column valid bits, so reset needs no pass.
// A stalled result register holds the sequencer; no new request is taken
// until the last result of the current one is in the output register.
// ----------------------------------------------------------------------------
`include "sparse_column_pattern_builder_macros.svh"

module sparse_column_pattern_builder
  import scpb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [5:0] column, [12:6] row_eqno, [15:13] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [1:0] op
  input  logic [OP_W-1:0]       in_tuser,
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [5:0] row_index, [15:6] packed_position, [20:16] column_length,
  // [31:21] total_nonzeros
  output logic [OUT_DATA_W-1:0] out_tdata,
  // [2:0] status, [3] empty_res, [4] list_end_echo
  output logic [OUT_USER_W-1:0] out_tuser,
  output logic                  out_tlast,
  input  logic                  cfg_wr_en,
  input  logic [EQN_W-1:0]      cfg_wr_data
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_CHECK  = 10'b00_0000_0010,
    S_SUM    = 10'b00_0000_0100,
    S_RSTART = 10'b00_0000_1000,
    S_RDATA  = 10'b00_0001_0000,
    S_SCAN   = 10'b00_0010_0000,
    S_DECIDE = 10'b00_0100_0000,
    S_SHIFT  = 10'b00_1000_0000,
    S_INS    = 10'b01_0000_0000,
    S_EMIT   = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [OP_W-1:0]          op_r, op_nxt;
  logic [COL_W-1:0]         col_r, col_nxt;
  logic [EQN_W-1:0]         req_r, req_nxt;
  logic                     le_r, le_nxt;
  logic [CNT_W-1:0]         len_r, len_nxt;
  logic [CNT_W-1:0]         j_r, j_nxt;
  logic [CNT_W-1:0]         k_r, k_nxt;
  logic [COL_W-1:0]         c_r, c_nxt;
  logic [POS_W-1:0]         start_r, start_nxt;
  logic [TOT_W-1:0]         total_r, total_nxt;
  logic [EQN_W-1:0]         cfg_r;
  logic [MAX_EQUATIONS-1:0] cnt_vld_r, cnt_vld_nxt;
  logic                     cnt_vld_q_r;

  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [ROW_W-1:0]    res_row_r, res_row_nxt;
  logic [POS_W-1:0]    res_pos_r, res_pos_nxt;
  logic [CNT_W-1:0]    res_len_r, res_len_nxt;
  logic                res_empty_r, res_empty_nxt;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [ROW_W-1:0]    out_row_r;
  logic [POS_W-1:0]    out_pos_r;
  logic [CNT_W-1:0]    out_len_r;
  logic [TOT_W-1:0]    out_total_r;
  logic                out_empty_r;
  logic                out_le_r;
  logic                out_last_r;

  logic                ld;
  logic [STATUS_W-1:0] ld_status;
  logic [ROW_W-1:0]    ld_row;
  logic [POS_W-1:0]    ld_pos;
  logic [CNT_W-1:0]    ld_len;
  logic                ld_empty;
  logic                ld_last;

  logic               st_wr_en, st_rd_en;
  logic [ST_AW-1:0]   st_wr_addr, st_rd_addr;
  logic [ROW_W-1:0]   st_wr_data, st_q;
  logic               cnt_wr_en, cnt_rd_en;
  logic [COL_W-1:0]   cnt_wr_addr, cnt_rd_addr;
  logic [CNT_W-1:0]   cnt_wr_data, cnt_q;

  logic [EQN_W-1:0] n_eff;
  logic [CNT_W-1:0] cnt_eff;
  logic [ROW_W-1:0] row;
  logic             out_free;

  function automatic logic [ST_AW-1:0] slot_addr(input logic [COL_W-1:0] c,
                                                 input logic [CNT_W-1:0] k);
    return ST_AW'(c) * ST_AW'(SLOTS_PER_COLUMN) + ST_AW'(k);
  endfunction

  scpb_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ST_DEPTH)
  ) u_row_store (
    .clk     (clk),
    .wr_en   (st_wr_en),
    .wr_addr (st_wr_addr),
    .wr_data (st_wr_data),
    .rd_en   (st_rd_en),
    .rd_addr (st_rd_addr),
    .rd_data (st_q)
  );

  scpb_ram #(
    .WIDTH (CNT_W),
    .DEPTH (MAX_EQUATIONS)
  ) u_col_count (
    .clk     (clk),
    .wr_en   (cnt_wr_en),
    .wr_addr (cnt_wr_addr),
    .wr_data (cnt_wr_data),
    .rd_en   (cnt_rd_en),
    .rd_addr (cnt_rd_addr),
    .rd_data (cnt_q)
  );

  always_comb begin
    if (cfg_r == '0) begin
      n_eff = EQN_W'(1);
    end else if (cfg_r > EQN_W'(MAX_EQUATIONS)) begin
      n_eff = EQN_W'(MAX_EQUATIONS);
    end else begin
      n_eff = cfg_r;
    end
  end

  // A column whose valid bit is clear has never been written since the last clear.
  assign cnt_eff  = cnt_vld_q_r ? cnt_q : '0;
  assign row      = ROW_W'(req_r - EQN_W'(1));
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    col_nxt        = col_r;
    req_nxt        = req_r;
    le_nxt         = le_r;
    len_nxt        = len_r;
    j_nxt          = j_r;
    k_nxt          = k_r;
    c_nxt          = c_r;
    start_nxt      = start_r;
    total_nxt      = total_r;
    cnt_vld_nxt    = cnt_vld_r;
    res_status_nxt = res_status_r;
    res_row_nxt    = res_row_r;
    res_pos_nxt    = res_pos_r;
    res_len_nxt    = res_len_r;
    res_empty_nxt  = res_empty_r;
    in_tready      = 1'b0;
    ld             = 1'b0;
    ld_status      = res_status_r;
    ld_row         = res_row_r;
    ld_pos         = res_pos_r;
    ld_len         = res_len_r;
    ld_empty       = res_empty_r;
    ld_last        = 1'b1;
    st_wr_en       = 1'b0;
    st_wr_addr     = slot_addr(col_r, j_r);
    st_wr_data     = row;
    st_rd_en       = 1'b0;
    st_rd_addr     = slot_addr(col_r, k_r);
    cnt_wr_en      = 1'b0;
    cnt_wr_addr    = col_r;
    cnt_wr_data    = CNT_W'(len_r + CNT_W'(1));
    cnt_rd_en      = 1'b0;
    cnt_rd_addr    = col_r;

    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          op_nxt      = in_tuser;
          col_nxt     = in_tdata[COL_W-1:0];
          req_nxt     = in_tdata[COL_W +: EQN_W];
          le_nxt      = in_tlast;
          cnt_rd_en   = 1'b1;
          cnt_rd_addr = in_tdata[COL_W-1:0];
          state_nxt   = S_CHECK;
        end
      end

      S_CHECK: begin
        res_status_nxt = ST_RANGE;
        res_row_nxt    = '0;
        res_pos_nxt    = '0;
        res_len_nxt    = '0;
        res_empty_nxt  = 1'b0;
        len_nxt        = cnt_eff;
        state_nxt      = S_EMIT;
        if (op_r == OP_CLEAR) begin
          res_status_nxt = ST_DONE;
          cnt_vld_nxt    = '0;
          total_nxt      = '0;
        end else if (op_r != OP_INSERT && op_r != OP_READ) begin
          res_status_nxt = ST_RANGE;
        end else if (EQN_W'(col_r) >= n_eff) begin
          res_status_nxt = ST_RANGE;
        end else if (op_r == OP_INSERT) begin
          res_len_nxt = cnt_eff;
          if (req_r == '0) begin
            res_status_nxt = ST_INACTIVE;
          end else if (req_r > n_eff) begin
            res_status_nxt = ST_RANGE;
          end else begin
            j_nxt = '0;
            if (cnt_eff == '0) begin
              state_nxt = S_DECIDE;
            end else begin
              st_rd_en   = 1'b1;
              st_rd_addr = slot_addr(col_r, '0);
              state_nxt  = S_SCAN;
            end
          end
        end else begin
          start_nxt = '0;
          c_nxt     = '0;
          if (col_r == '0) begin
            state_nxt = S_RSTART;
          end else begin
            cnt_rd_en   = 1'b1;
            cnt_rd_addr = '0;
            state_nxt   = S_SUM;
          end
        end
      end

      // One column length a cycle; the next read is issued while this one adds.
      S_SUM: begin
        start_nxt = POS_W'(start_r + POS_W'(cnt_eff));
        c_nxt     = COL_W'(c_r + COL_W'(1));
        if (COL_W'(c_r + COL_W'(1)) == col_r) begin
          state_nxt = S_RSTART;
        end else begin
          cnt_rd_en   = 1'b1;
          cnt_rd_addr = COL_W'(c_r + COL_W'(1));
        end
      end

      S_RSTART: begin
        if (len_r == '0) begin
          res_status_nxt = ST_ENTRY;
          res_row_nxt    = '0;
          res_pos_nxt    = start_r;
          res_len_nxt    = '0;
          res_empty_nxt  = 1'b1;
          state_nxt      = S_EMIT;
        end else begin
          k_nxt      = '0;
          st_rd_en   = 1'b1;
          st_rd_addr = slot_addr(col_r, '0);
          state_nxt  = S_RDATA;
        end
      end

      // The slot read data holds while the output register is stalled.
      S_RDATA: begin
        if (out_free) begin
          ld        = 1'b1;
          ld_status = ST_ENTRY;
          ld_row    = st_q;
          ld_pos    = POS_W'(start_r + POS_W'(k_r));
          ld_len    = len_r;
          ld_empty  = 1'b0;
          ld_last   = (CNT_W'(k_r + CNT_W'(1)) == len_r);
          k_nxt     = CNT_W'(k_r + CNT_W'(1));
          if (CNT_W'(k_r + CNT_W'(1)) == len_r) begin
            state_nxt = S_IDLE;
          end else begin
            st_rd_en   = 1'b1;
            st_rd_addr = slot_addr(col_r, CNT_W'(k_r + CNT_W'(1)));
          end
        end
      end

      S_SCAN: begin
        if (st_q == row) begin
          res_status_nxt = ST_PRESENT;
          res_row_nxt    = row;
          res_len_nxt    = len_r;
          state_nxt      = S_EMIT;
        end else if (row < st_q) begin
          state_nxt = S_DECIDE;
        end else begin
          j_nxt = CNT_W'(j_r + CNT_W'(1));
          if (CNT_W'(j_r + CNT_W'(1)) == len_r) begin
            state_nxt = S_DECIDE;
          end else begin
            st_rd_en   = 1'b1;
            st_rd_addr = slot_addr(col_r, CNT_W'(j_r + CNT_W'(1)));
          end
        end
      end

      S_DECIDE: begin
        if (len_r >= CNT_W'(SLOTS_PER_COLUMN)) begin
          res_status_nxt = ST_FULL;
          res_row_nxt    = row;
          res_len_nxt    = len_r;
          state_nxt      = S_EMIT;
        end else if (len_r == j_r) begin
          state_nxt = S_INS;
        end else begin
          k_nxt      = len_r;
          st_rd_en   = 1'b1;
          st_rd_addr = slot_addr(col_r, CNT_W'(len_r - CNT_W'(1)));
          state_nxt  = S_SHIFT;
        end
      end

      // Moves slot k-1 to slot k, top down, until the insert point is free.
      S_SHIFT: begin
        st_wr_en   = 1'b1;
        st_wr_addr = slot_addr(col_r, k_r);
        st_wr_data = st_q;
        k_nxt      = CNT_W'(k_r - CNT_W'(1));
        if (CNT_W'(k_r - CNT_W'(1)) == j_r) begin
          state_nxt = S_INS;
        end else begin
          st_rd_en   = 1'b1;
          st_rd_addr = slot_addr(col_r, CNT_W'(k_r - CNT_W'(2)));
        end
      end

      S_INS: begin
        st_wr_en              = 1'b1;
        st_wr_addr            = slot_addr(col_r, j_r);
        st_wr_data            = row;
        cnt_wr_en             = 1'b1;
        cnt_vld_nxt[col_r]    = 1'b1;
        total_nxt             = TOT_W'(total_r + TOT_W'(1));
        res_status_nxt        = ST_DONE;
        res_row_nxt           = row;
        res_len_nxt           = CNT_W'(len_r + CNT_W'(1));
        state_nxt             = S_EMIT;
      end

      S_EMIT: begin
        if (out_free) begin
          ld        = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= '0;
      cfg_r       <= EQN_W'(MAX_EQUATIONS);
      cnt_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      total_r   <= total_nxt;
      cnt_vld_r <= cnt_vld_nxt;
      if (cfg_wr_en) begin
        cfg_r <= cfg_wr_data;
      end
      if (ld) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    col_r        <= col_nxt;
    req_r        <= req_nxt;
    le_r         <= le_nxt;
    len_r        <= len_nxt;
    j_r          <= j_nxt;
    k_r          <= k_nxt;
    c_r          <= c_nxt;
    start_r      <= start_nxt;
    res_status_r <= res_status_nxt;
    res_row_r    <= res_row_nxt;
    res_pos_r    <= res_pos_nxt;
    res_len_r    <= res_len_nxt;
    res_empty_r  <= res_empty_nxt;
    if (cnt_rd_en) begin
      cnt_vld_q_r <= cnt_vld_r[cnt_rd_addr];
    end
    if (ld) begin
      out_status_r <= ld_status;
      out_row_r    <= ld_row;
      out_pos_r    <= ld_pos;
      out_len_r    <= ld_len;
      out_total_r  <= total_r;
      out_empty_r  <= ld_empty;
      out_le_r     <= le_r;
      out_last_r   <= ld_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_total_r, out_len_r, out_pos_r, out_row_r};
  assign out_tuser  = {out_le_r, out_empty_r, out_status_r};
  assign out_tlast  = out_last_r;

  `SCPB_ASSERT_NEXT(a_accept_check, (in_tvalid && in_tready), (state_r == S_CHECK),
    "accepted request did not move to the check state")
  `SCPB_ASSERT_NOW(a_shift_bounds, (state_r == S_SHIFT),
    (k_r > j_r && k_r <= CNT_W'(SLOTS_PER_COLUMN)), "shift left its column")
  `SCPB_ASSERT_NOW(a_store_write, st_wr_en, (state_r == S_SHIFT || state_r == S_INS),
    "slot memory written outside an insert")
  `SCPB_ASSERT_NEXT(a_total_step, (state_r == S_INS),
    (total_r == $past(total_r) + TOT_W'(1)), "total count not advanced by an insert")

endmodule
